FILE: rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bilinear bayer demosaic block.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int PIX_W      = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int SLOTS      = 3;
    localparam int SLOT_W     = 2;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(2);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // which columns of the window are replicated at the row edges
    typedef enum logic [1:0] {
        COL_FIRST  = 2'b00,
        COL_SECOND = 2'b01,
        COL_INNER  = 2'b10
    } bbd_col_mode_t;

    // one column of the 3x3 window, rows above, at and below the center
    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] low;
    } bbd_col_t;

    typedef struct packed {
        bbd_col_t left;
        bbd_col_t center;
        bbd_col_t right;
    } bbd_window_t;

    typedef struct packed {
        logic odd_row;
        logic odd_col;
    } bbd_site_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } bbd_rgb_t;

    typedef struct packed {
        logic            emit;
        bbd_col_mode_t   col_mode;
        logic            up_clamp;
        logic            low_clamp;
        logic [SLOT_W-1:0] mid_sel;
        logic [SLOT_W-1:0] up_sel;
        bbd_site_t       site;
        logic            eor;
        logic            eof;
    } bbd_ctrl_t;

endpackage

FILE: rtl/bayer_bilinear_demosaic.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming bilinear demosaic of a GRBG raw mosaic into RGB pixels.
//
// channel   dir  payload                                   handshake
// s_axis    in   tdata: raw_sample; tuser: flush            tvalid/tready
// m_axis    out  tdata: red, green, blue; tlast: end_of_row tvalid/tready
//                tuser: end_of_frame
// cfg       in   cfg_index, cfg_data                       cfg_we
//
// one word per clock while m_axis accepts; a result passes the window stage, then the output register
// three rotating 1024x8 line memories hold the rows, read at the input or drain column
// a pixel comes out with its lower-right neighbour, one row plus one word after its own sample
// flush words at frame start drain the last row
// stalls on m_axis back up through a two-stage pipeline; reset clears counters
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // raw_sample
    input  logic                              s_axis_tuser,  // flush

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // red, green, blue
    output logic                              m_axis_tlast,  // end_of_row
    output logic                              m_axis_tuser,  // end_of_frame

    input  logic                              cfg_we,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W    = bbd_pkg::COL_W;
    localparam int WIDTH_W  = bbd_pkg::WIDTH_W;
    localparam int HEIGHT_W = bbd_pkg::HEIGHT_W;
    localparam int PIX_W    = bbd_pkg::PIX_W;
    localparam int SLOT_W   = bbd_pkg::SLOT_W;

    logic [WIDTH_W-1:0]  w_reg;
    logic [HEIGHT_W-1:0] h_reg;
    logic [COL_W-1:0]    in_col_reg;
    logic [HEIGHT_W-1:0] in_row_reg;
    logic [SLOT_W-1:0]   in_slot_reg;
    logic [COL_W-1:0]    drain_col_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [HEIGHT_W-1:0] out_row_reg;
    logic [WIDTH_W-1:0]  pending_reg;

    logic                s1_valid_reg;
    bbd_pkg::bbd_ctrl_t  s1_ctrl_reg;
    logic [PIX_W-1:0]    s1_sample_reg;

    bbd_pkg::bbd_col_t   win_p1_reg;
    bbd_pkg::bbd_col_t   win_p2_reg;

    logic                out_valid_reg;
    bbd_pkg::bbd_rgb_t   out_pix_reg;
    logic                out_eor_reg;
    logic                out_eof_reg;

    logic [PIX_W-1:0]    rd_data [bbd_pkg::SLOTS];

    logic                out_free;
    logic                s1_go;
    logic                in_acc;
    logic                is_sample;
    logic                drain_ok;
    logic                emit0;
    logic                act0;
    logic [COL_W-1:0]    ic0;
    logic                in_col_last;
    logic                in_row_last;
    logic                drain_col_last;
    logic                out_col_last;
    logic                out_row_last;
    bbd_pkg::bbd_ctrl_t  ctrl0;

    bbd_pkg::bbd_col_t    vec;
    bbd_pkg::bbd_window_t win;
    bbd_pkg::bbd_rgb_t    pix;
    logic [PIX_W-1:0]     mid_val;

    logic [WIDTH_W-1:0]  w_next;
    logic [HEIGHT_W-1:0] h_next;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_go         = s1_valid_reg && (!s1_ctrl_reg.emit || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // input stage decode
    // ------------------------------------------------------------------
    assign is_sample      = !s_axis_tuser;
    assign drain_ok       = (pending_reg != '0) && (in_row_reg == '0) && (in_col_reg == '0);
    assign emit0          = is_sample ? (pending_reg >= w_reg + WIDTH_W'(1)) : drain_ok;
    assign act0           = is_sample || drain_ok;
    assign ic0            = is_sample ? in_col_reg : drain_col_reg;

    assign in_col_last    = {1'b0, in_col_reg} == w_reg - WIDTH_W'(1);
    assign drain_col_last = {1'b0, drain_col_reg} == w_reg - WIDTH_W'(1);
    assign out_col_last   = {1'b0, out_col_reg} == w_reg - WIDTH_W'(1);
    assign in_row_last    = in_row_reg == h_reg - HEIGHT_W'(1);
    assign out_row_last   = out_row_reg == h_reg - HEIGHT_W'(1);

    function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == '0) ? SLOT_W'(bbd_pkg::SLOTS - 1) : s - SLOT_W'(1);
        return r;
    endfunction

    always_comb
    begin
        ctrl0.emit = emit0;
        if (ic0 == '0)
            ctrl0.col_mode = bbd_pkg::COL_FIRST;
        else if (ic0 == COL_W'(1))
            ctrl0.col_mode = bbd_pkg::COL_SECOND;
        else
            ctrl0.col_mode = bbd_pkg::COL_INNER;
        // the window row is one behind the input row
        ctrl0.up_clamp     = in_row_reg == HEIGHT_W'(1);
        ctrl0.low_clamp    = in_row_reg == '0;
        ctrl0.mid_sel      = slot_prev(in_slot_reg);
        ctrl0.up_sel       = slot_prev(slot_prev(in_slot_reg));
        ctrl0.site.odd_row = out_row_reg[0];
        ctrl0.site.odd_col = out_col_reg[0];
        ctrl0.eor          = out_col_last;
        ctrl0.eof          = out_col_last && out_row_last;
    end

    // ------------------------------------------------------------------
    // line memories, one per row slot
    // ------------------------------------------------------------------
    for (genvar k = 0; k < bbd_pkg::SLOTS; k++)
    begin : g_line
        logic [PIX_W-1:0] line_mem [bbd_pkg::MAX_WIDTH];
        logic [PIX_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (in_acc && is_sample && !cfg_we && in_slot_reg == SLOT_W'(k))
                line_mem[in_col_reg] <= s_axis_tdata;
            if (in_acc && act0)
                rd_reg <= line_mem[ic0];
        end

        assign rd_data[k] = rd_reg;
    end

    // ------------------------------------------------------------------
    // configuration, clamped on write
    // ------------------------------------------------------------------
    always_comb
    begin
        w_next = cfg_data[WIDTH_W-1:0];
        if (w_next < bbd_pkg::WIDTH_MIN)
            w_next = bbd_pkg::WIDTH_MIN;
        else if (w_next > bbd_pkg::WIDTH_MAX)
            w_next = bbd_pkg::WIDTH_MAX;
        h_next = cfg_data[HEIGHT_W-1:0];
        if (h_next < bbd_pkg::HEIGHT_MIN)
            h_next = bbd_pkg::HEIGHT_MIN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= bbd_pkg::WIDTH_RESET;
            h_reg <= bbd_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bbd_pkg::REG_FRAME_WIDTH:  w_reg <= w_next;
                bbd_pkg::REG_FRAME_HEIGHT: h_reg <= h_next;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // position counters
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            drain_col_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pending_reg   <= '0;
        end
        else if (cfg_we)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            drain_col_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pending_reg   <= '0;
        end
        else if (in_acc)
        begin
            if (is_sample)
            begin
                if (!emit0)
                    pending_reg <= pending_reg + WIDTH_W'(1);
                drain_col_reg <= '0;
                if (in_col_last)
                begin
                    in_col_reg  <= '0;
                    in_slot_reg <= (in_slot_reg == SLOT_W'(bbd_pkg::SLOTS - 1)) ?
                                   '0 : in_slot_reg + SLOT_W'(1);
                    in_row_reg  <= in_row_last ? '0 : in_row_reg + HEIGHT_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            else if (drain_ok)
            begin
                pending_reg   <= pending_reg - WIDTH_W'(1);
                drain_col_reg <= drain_col_last ? '0 : drain_col_reg + COL_W'(1);
            end

            if (emit0)
            begin
                if (out_col_last)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_last ? '0 : out_row_reg + HEIGHT_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // window stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cfg_we)
            s1_valid_reg <= 1'b0;
        else if (in_acc && act0)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && act0)
        begin
            s1_ctrl_reg   <= ctrl0;
            s1_sample_reg <= s_axis_tdata;
        end
    end

    // column vector at the input column, rows replicated at frame top and bottom
    always_comb
    begin
        mid_val = rd_data[s1_ctrl_reg.mid_sel];
        vec.mid = mid_val;
        vec.up  = s1_ctrl_reg.up_clamp ? mid_val : rd_data[s1_ctrl_reg.up_sel];
        vec.low = s1_ctrl_reg.low_clamp ? mid_val : s1_sample_reg;
    end

    always_comb
    begin
        unique case (s1_ctrl_reg.col_mode)
            bbd_pkg::COL_FIRST:
            begin
                // new row started: pixel is the last column of the previous row
                win.left   = win_p2_reg;
                win.center = win_p1_reg;
                win.right  = win_p1_reg;
            end
            bbd_pkg::COL_SECOND:
            begin
                win.left   = win_p1_reg;
                win.center = win_p1_reg;
                win.right  = vec;
            end
            default:
            begin
                win.left   = win_p2_reg;
                win.center = win_p1_reg;
                win.right  = vec;
            end
        endcase
    end

    bbd_interp u_interp
    (
        .win  (win),
        .site (s1_ctrl_reg.site),
        .pix  (pix)
    );

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            win_p2_reg <= win_p1_reg;
            win_p1_reg <= vec;
        end
        if (s1_go && s1_ctrl_reg.emit)
        begin
            out_pix_reg <= pix;
            out_eor_reg <= s1_ctrl_reg.eor;
            out_eof_reg <= s1_ctrl_reg.eof;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cfg_we)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_ctrl_reg.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pix_reg.blue, out_pix_reg.green, out_pix_reg.red};
    assign m_axis_tlast  = out_eor_reg;
    assign m_axis_tuser  = out_eof_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= w_reg + WIDTH_W'(1))
        else $error("pending count beyond one row plus one");

    a_eof_on_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_eof_reg |-> out_eor_reg)
        else $error("end of frame without end of row");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_slot_reg != 2'd3)
        else $error("row slot out of range");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go && !cfg_we |=> s1_valid_reg && $stable(s1_ctrl_reg))
        else $error("window stage lost a stalled word");

endmodule

FILE: rtl/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear interpolation of one GRBG site from its 3x3 window.
// ----------------------------------------------------------------------------
module bbd_interp
(
    input  bbd_pkg::bbd_window_t win,
    input  bbd_pkg::bbd_site_t   site,
    output bbd_pkg::bbd_rgb_t    pix
);

    logic [bbd_pkg::PIX_W:0]   horiz_sum;
    logic [bbd_pkg::PIX_W:0]   vert_sum;
    logic [bbd_pkg::PIX_W+1:0] cross_sum;
    logic [bbd_pkg::PIX_W+1:0] diag_sum;
    logic [bbd_pkg::PIX_W-1:0] horiz;
    logic [bbd_pkg::PIX_W-1:0] vert;
    logic [bbd_pkg::PIX_W-1:0] cross_avg;
    logic [bbd_pkg::PIX_W-1:0] diag;

    assign horiz_sum = {1'b0, win.left.mid} + {1'b0, win.right.mid};
    assign vert_sum  = {1'b0, win.center.up} + {1'b0, win.center.low};
    assign cross_sum = {1'b0, horiz_sum} + {1'b0, vert_sum};
    assign diag_sum  = {2'b00, win.left.up} + {2'b00, win.right.up}
                     + {2'b00, win.left.low} + {2'b00, win.right.low};

    assign horiz     = horiz_sum[bbd_pkg::PIX_W:1];
    assign vert      = vert_sum[bbd_pkg::PIX_W:1];
    assign cross_avg = cross_sum[bbd_pkg::PIX_W+1:2];
    assign diag      = diag_sum[bbd_pkg::PIX_W+1:2];

    always_comb
    begin
        if (site.odd_row == site.odd_col)
        begin
            // green site
            pix.green = win.center.mid;
            if (!site.odd_row)
            begin
                pix.red  = horiz;
                pix.blue = vert;
            end
            else
            begin
                pix.blue = horiz;
                pix.red  = vert;
            end
        end
        else if (!site.odd_row)
        begin
            // red site
            pix.red   = win.center.mid;
            pix.green = cross_avg;
            pix.blue  = diag;
        end
        else
        begin
            // blue site
            pix.blue  = win.center.mid;
            pix.green = cross_avg;
            pix.red   = diag;
        end
    end

endmodule
